>>> rtl/rrpt_pkg.sv
// Shared types and constants for the round-robin process table.
// No dependencies; imported by every module of the block.
package rrpt_pkg;

    localparam int SLOT_COUNT   = 8;
    localparam int PID_W        = 3;
    localparam int PARENT_W     = 4;
    localparam int TARGET_W     = 4;
    localparam int WORD_W       = 32;
    localparam int STACK_BYTES  = 16384;
    localparam int FRAME_WORDS  = 20;
    localparam int FRAME_OFFSET = (STACK_BYTES / 4 - FRAME_WORDS) * 4;

    localparam logic [PARENT_W-1:0] NO_PARENT  = 4'd15;
    localparam logic                LVL_USER   = 1'b0;
    localparam logic                LVL_SYSTEM = 1'b1;

    typedef enum logic [1:0] {
        CMD_SWITCH = 2'd0,
        CMD_SPAWN  = 2'd1,
        CMD_KILL   = 2'd2,
        CMD_EXIT   = 2'd3
    } rrpt_cmd_code_t;

    typedef enum logic [1:0] {
        SLOT_FREE   = 2'd0,
        SLOT_READY  = 2'd1,
        SLOT_RUN    = 2'd2,
        SLOT_ZOMBIE = 2'd3
    } rrpt_slot_state_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [WORD_W-1:0]   stack_pointer;
        logic                spawn_level;
        logic [2:0]          spawn_parent;
        logic [TARGET_W-1:0] target_pid;
    } rrpt_in_t;

    typedef struct packed {
        logic              status;
        logic [2:0]        pid;
        logic [WORD_W-1:0] resume_pointer;
        logic              yield_needed;
    } rrpt_out_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_LOAD,
        FSM_DECIDE,
        FSM_ADOPT,
        FSM_SCAN,
        FSM_FINISH
    } rrpt_fsm_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD,
        OP_DECIDE,
        OP_ADOPT,
        OP_SCAN,
        OP_FINISH
    } rrpt_op_t;

    typedef struct packed {
        rrpt_op_t op;
    } rrpt_ctl_t;

    typedef struct packed {
        rrpt_cmd_code_t command;
        logic           refuse;
        logic           hit;
        logic           last;
        logic           out_busy;
    } rrpt_stat_t;

    function automatic logic [PID_W-1:0] next_slot(input logic [PID_W-1:0] slot);
        logic [PID_W-1:0] result;
        if (slot == PID_W'(SLOT_COUNT - 1))
        begin
            result = '0;
        end
        else
        begin
            result = slot + PID_W'(1);
        end
        return result;
    endfunction

endpackage

>>> rtl/round_robin_process_table.sv
// Top level of the round-robin process table.
// Depends on rrpt_pkg; instantiates rrpt_ctrl and rrpt_dp.
//
// Usage:
//   in channel  (in_valid / in_stall / in_data): one command beat, switch,
//   spawn, kill or exit. in_stall is low only while the sequencer is idle.
//   out channel (out_valid / out_stall / out_data): one result beat per
//   command, held in an output register until the receiver drops out_stall.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes the stack region
//   base; cfg_ready is always high. Write it only while the block is idle.
// Steps, from accepted command beat to result beat valid:
//   switch: load, walk k = 1..8 slots round-robin, finish;
//   spawn: load, search k = 1..7 slots from slot 1, finish;
//   kill: load and target check, decide, eight-slot reparent walk, finish;
//   exit: load, eight-slot reparent walk, finish. Refusals skip to finish.
// One command is in flight at a time; the slot walk is the rate limit.
// A new command is taken while an earlier result still waits in the output
// register; it finishes and holds until that beat is taken.
// Reset: slot 0 running as a system process with no parent, the rest free,
// running pid 0, base 0. Saved pointers are undefined until written.
module round_robin_process_table
    import rrpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rrpt_in_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output rrpt_out_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data
);

    rrpt_ctl_t  ctl;
    rrpt_stat_t stat;

    rrpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    rrpt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

>>> rtl/rrpt_ctrl.sv
// Sequencer for the process table: one command beat at a time.
// Depends on rrpt_pkg; drives rrpt_dp through rrpt_ctl_t, reads rrpt_stat_t.
module rrpt_ctrl
    import rrpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  rrpt_stat_t stat,
    output rrpt_ctl_t  ctl
);

    rrpt_fsm_t state_reg;
    rrpt_fsm_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = FSM_LOAD;
                end
            end
            FSM_LOAD:
            begin
                unique case (stat.command)
                    CMD_SWITCH: state_next = FSM_SCAN;
                    CMD_SPAWN:  state_next = stat.refuse ? FSM_FINISH : FSM_SCAN;
                    CMD_KILL:   state_next = stat.refuse ? FSM_FINISH : FSM_DECIDE;
                    CMD_EXIT:   state_next = FSM_ADOPT;
                    default:    state_next = FSM_FINISH;
                endcase
            end
            FSM_DECIDE:
            begin
                state_next = stat.refuse ? FSM_FINISH : FSM_ADOPT;
            end
            FSM_ADOPT:
            begin
                if (stat.last)
                begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_SCAN:
            begin
                if (stat.hit || stat.last)
                begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        ctl.op   = OP_NONE;
        unique case (state_reg)
            FSM_IDLE:
            begin
                in_stall = 1'b0;
                ctl.op   = in_valid ? OP_LATCH : OP_NONE;
            end
            FSM_LOAD:   ctl.op = OP_LOAD;
            FSM_DECIDE: ctl.op = OP_DECIDE;
            FSM_ADOPT:  ctl.op = OP_ADOPT;
            FSM_SCAN:   ctl.op = OP_SCAN;
            FSM_FINISH: ctl.op = stat.out_busy ? OP_NONE : OP_FINISH;
            default:    ctl.op = OP_NONE;
        endcase
    end

endmodule

>>> rtl/rrpt_dp.sv
// Datapath: slot table, saved-pointer memory, scan index and result register.
// Depends on rrpt_pkg; stepped by rrpt_ctrl through rrpt_ctl_t.
module rrpt_dp
    import rrpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rrpt_ctl_t         ctl,
    output rrpt_stat_t        stat,
    input  rrpt_in_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output rrpt_out_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data
);

    rrpt_slot_state_t    slot_state_reg  [SLOT_COUNT];
    logic                slot_level_reg  [SLOT_COUNT];
    logic [PARENT_W-1:0] slot_parent_reg [SLOT_COUNT];
    logic [WORD_W-1:0]   ptr_mem         [SLOT_COUNT];

    rrpt_in_t            in_reg;
    logic [WORD_W-1:0]   base_reg;
    logic [PID_W-1:0]    running_reg,   running_next;
    logic                me_level_reg,  me_level_next;
    logic [PID_W-1:0]    idx_reg,       idx_next;
    logic [PID_W-1:0]    cnt_reg,       cnt_next;
    logic [PID_W-1:0]    old_par_reg,   old_par_next;
    logic [PARENT_W-1:0] new_par_reg,   new_par_next;
    logic                status_reg,    status_next;
    logic [PID_W-1:0]    pid_reg,       pid_next;
    logic                yield_reg,     yield_next;
    logic [WORD_W-1:0]   rdata_reg;
    rrpt_out_t           out_reg;
    logic                out_valid_reg;

    logic [PID_W-1:0]    rd_addr;
    rrpt_slot_state_t    rd_state;
    logic                rd_level;
    logic [PARENT_W-1:0] rd_parent;
    rrpt_cmd_code_t      cmd;
    logic [PID_W-1:0]    tgt_slot;
    logic                tgt_bad;
    logic                kill_refuse;
    logic [PID_W-1:0]    pick;

    logic                st_we;
    logic [PID_W-1:0]    st_wa;
    rrpt_slot_state_t    st_wd;
    logic                lv_we;
    logic                lv_wd;
    logic                pa_we;
    logic [PID_W-1:0]    pa_wa;
    logic [PARENT_W-1:0] pa_wd;
    logic                mem_we;
    logic [PID_W-1:0]    mem_wa;
    logic [WORD_W-1:0]   mem_wd;
    logic                mem_re;
    logic [PID_W-1:0]    mem_ra;

    assign cmd       = rrpt_cmd_code_t'(in_reg.command);
    assign tgt_slot  = in_reg.target_pid[PID_W-1:0];
    assign tgt_bad   = (in_reg.target_pid == '0) ||
                       (int'(in_reg.target_pid) >= SLOT_COUNT);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        case (ctl.op)
            OP_LOAD:   rd_addr = running_reg;
            OP_DECIDE: rd_addr = tgt_slot;
            default:   rd_addr = idx_reg;
        endcase
    end

    assign rd_state  = slot_state_reg[rd_addr];
    assign rd_level  = slot_level_reg[rd_addr];
    assign rd_parent = slot_parent_reg[rd_addr];

    assign kill_refuse = (rd_state == SLOT_FREE) ||
                         ((me_level_reg == LVL_USER) &&
                          (((tgt_slot != running_reg) &&
                            (rd_parent != PARENT_W'(running_reg))) ||
                           (rd_level == LVL_SYSTEM)));

    always_comb
    begin
        stat.command  = cmd;
        stat.refuse   = 1'b0;
        stat.hit      = 1'b0;
        stat.last     = 1'b0;
        stat.out_busy = out_valid_reg && out_stall;
        case (ctl.op)
            OP_LOAD:
            begin
                case (cmd)
                    CMD_SPAWN: stat.refuse = in_reg.spawn_level > rd_level;
                    CMD_KILL:  stat.refuse = tgt_bad;
                    default:   stat.refuse = 1'b0;
                endcase
            end
            OP_DECIDE:
            begin
                stat.refuse = kill_refuse;
            end
            OP_ADOPT:
            begin
                stat.last = idx_reg == PID_W'(SLOT_COUNT - 1);
            end
            OP_SCAN:
            begin
                if (cmd == CMD_SWITCH)
                begin
                    stat.hit  = (rd_state == SLOT_READY) || (rd_state == SLOT_RUN);
                    stat.last = cnt_reg == PID_W'(SLOT_COUNT - 1);
                end
                else
                begin
                    stat.hit  = rd_state == SLOT_FREE;
                    stat.last = idx_reg == PID_W'(SLOT_COUNT - 1);
                end
            end
            default:
            begin
                stat.refuse = 1'b0;
            end
        endcase
    end

    assign pick = stat.hit ? idx_reg : running_reg;

    always_comb
    begin
        running_next  = running_reg;
        me_level_next = me_level_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        old_par_next  = old_par_reg;
        new_par_next  = new_par_reg;
        status_next   = status_reg;
        pid_next      = pid_reg;
        yield_next    = yield_reg;
        st_we         = 1'b0;
        st_wa         = rd_addr;
        st_wd         = SLOT_FREE;
        lv_we         = 1'b0;
        lv_wd         = in_reg.spawn_level;
        pa_we         = 1'b0;
        pa_wa         = rd_addr;
        pa_wd         = new_par_reg;
        mem_we        = 1'b0;
        mem_wa        = rd_addr;
        mem_wd        = in_reg.stack_pointer;
        mem_re        = 1'b0;
        mem_ra        = pick;
        case (ctl.op)
            OP_LATCH:
            begin
                status_next = 1'b0;
                pid_next    = '0;
                yield_next  = 1'b0;
            end
            OP_LOAD:
            begin
                me_level_next = rd_level;
                status_next   = stat.refuse;
                case (cmd)
                    CMD_SWITCH:
                    begin
                        mem_we   = 1'b1;
                        idx_next = next_slot(running_reg);
                        cnt_next = '0;
                        if (rd_state == SLOT_ZOMBIE)
                        begin
                            st_we = 1'b1;
                            st_wd = SLOT_FREE;
                        end
                        else if (rd_state == SLOT_RUN)
                        begin
                            st_we = 1'b1;
                            st_wd = SLOT_READY;
                        end
                    end
                    CMD_SPAWN:
                    begin
                        idx_next = PID_W'(1);
                    end
                    CMD_EXIT:
                    begin
                        st_we        = 1'b1;
                        st_wd        = SLOT_ZOMBIE;
                        old_par_next = running_reg;
                        new_par_next = rd_parent;
                        idx_next     = '0;
                        yield_next   = 1'b1;
                    end
                    default:
                    begin
                        idx_next = '0;
                    end
                endcase
            end
            OP_DECIDE:
            begin
                status_next = kill_refuse;
                if (!kill_refuse)
                begin
                    st_we        = 1'b1;
                    st_wd        = SLOT_FREE;
                    old_par_next = tgt_slot;
                    new_par_next = rd_parent;
                    idx_next     = '0;
                    yield_next   = tgt_slot == running_reg;
                end
            end
            OP_ADOPT:
            begin
                if ((rd_state != SLOT_FREE) && (rd_parent == PARENT_W'(old_par_reg)))
                begin
                    pa_we = 1'b1;
                end
                idx_next = next_slot(idx_reg);
            end
            OP_SCAN:
            begin
                idx_next = next_slot(idx_reg);
                cnt_next = cnt_reg + PID_W'(1);
                if (cmd == CMD_SWITCH)
                begin
                    if (stat.hit || stat.last)
                    begin
                        st_we        = 1'b1;
                        st_wa        = pick;
                        st_wd        = SLOT_RUN;
                        running_next = pick;
                        pid_next     = pick;
                        mem_re       = 1'b1;
                    end
                end
                else if (stat.hit)
                begin
                    st_we    = 1'b1;
                    st_wd    = SLOT_READY;
                    lv_we    = 1'b1;
                    pa_we    = 1'b1;
                    pa_wd    = PARENT_W'(in_reg.spawn_parent);
                    mem_we   = 1'b1;
                    mem_wd   = base_reg + WORD_W'(idx_reg) * WORD_W'(STACK_BYTES)
                               + WORD_W'(FRAME_OFFSET);
                    pid_next = idx_reg;
                end
                else if (stat.last)
                begin
                    status_next = 1'b1;
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_state_reg[i]  <= SLOT_FREE;
                slot_level_reg[i]  <= LVL_USER;
                slot_parent_reg[i] <= '0;
            end
            slot_state_reg[0]  <= SLOT_RUN;
            slot_level_reg[0]  <= LVL_SYSTEM;
            slot_parent_reg[0] <= NO_PARENT;
            running_reg        <= '0;
            base_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (st_we)
            begin
                slot_state_reg[st_wa] <= st_wd;
            end
            if (lv_we)
            begin
                slot_level_reg[idx_reg] <= lv_wd;
            end
            if (pa_we)
            begin
                slot_parent_reg[pa_wa] <= pa_wd;
            end
            running_reg <= running_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
            if (ctl.op == OP_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LATCH)
        begin
            in_reg <= in_data;
        end
        me_level_reg <= me_level_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        old_par_reg  <= old_par_next;
        new_par_reg  <= new_par_next;
        status_reg   <= status_next;
        pid_reg      <= pid_next;
        yield_reg    <= yield_next;
        if (ctl.op == OP_FINISH)
        begin
            out_reg.status         <= status_reg;
            out_reg.pid            <= pid_reg;
            out_reg.resume_pointer <= (cmd == CMD_SWITCH) ? rdata_reg : '0;
            out_reg.yield_needed   <= yield_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ptr_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= ptr_mem[mem_ra];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_switch_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_SCAN && cmd == CMD_SWITCH && (stat.hit || stat.last))
        |=> (slot_state_reg[running_reg] == SLOT_RUN))
        else $error("switch left the chosen slot not running");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_FINISH) |-> !(out_valid_reg && out_stall))
        else $error("result beat loaded over a stalled beat");

    a_switch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_FINISH && cmd == CMD_SWITCH) |-> (!yield_reg && !status_reg))
        else $error("switch result carries refuse or yield");

    a_spawn_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_SCAN && cmd == CMD_SPAWN && stat.hit)
        |=> (slot_state_reg[$past(idx_reg)] == SLOT_READY))
        else $error("spawned slot not marked ready");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for round_robin_process_table: directed and random commands,
// each result beat checked against a process table kept in step with the block.
// Depends on rrpt_pkg and the RTL of round_robin_process_table.
`timescale 1ns / 100ps

module tb
    import rrpt_pkg::*;
();

    localparam int SETTLE_CYCLES = 16;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    rrpt_in_t          in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    rrpt_out_t         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [WORD_W-1:0] cfg_data  = '0;

    rrpt_slot_state_t    slot_st  [SLOT_COUNT];
    logic                slot_lvl [SLOT_COUNT];
    logic [PARENT_W-1:0] slot_par [SLOT_COUNT];
    logic [WORD_W-1:0]   slot_sp  [SLOT_COUNT];
    logic [PID_W-1:0]    cur_pid;
    logic [WORD_W-1:0]   stack_base;

    rrpt_out_t replies_due[$];
    rrpt_out_t reply_head;

    int send_gap_pct     = 0;
    int stall_pct        = 0;
    int commands_by_code[4];
    int refusals         = 0;
    int replies_checked  = 0;
    int mismatches       = 0;

    round_robin_process_table uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void adopt_orphans(input logic [PARENT_W-1:0] old_parent,
                                          input logic [PARENT_W-1:0] heir);
        foreach (slot_st[i])
        begin
            if (slot_st[i] != SLOT_FREE && slot_par[i] == old_parent)
                slot_par[i] = heir;
        end
    endfunction

    function automatic rrpt_out_t run_scheduler_command(input rrpt_in_t cmd);
        rrpt_out_t        res;
        logic [PID_W-1:0] me;
        logic [PID_W-1:0] victim;
        int               pick;
        int               slot;
        int               n;
        bit               found;
        res   = '0;
        me    = cur_pid;
        pick  = int'(me);
        found = 1'b0;
        case (cmd.command)
            CMD_SWITCH:
            begin
                slot_sp[me] = cmd.stack_pointer;
                if (slot_st[me] == SLOT_ZOMBIE)
                    slot_st[me] = SLOT_FREE;
                else if (slot_st[me] == SLOT_RUN)
                    slot_st[me] = SLOT_READY;
                for (n = 1; n <= SLOT_COUNT; n++)
                begin
                    slot = (int'(me) + n) % SLOT_COUNT;
                    if (!found && (slot_st[slot] == SLOT_READY || slot_st[slot] == SLOT_RUN))
                    begin
                        found = 1'b1;
                        pick  = slot;
                    end
                end
                cur_pid             = PID_W'(pick);
                slot_st[pick]       = SLOT_RUN;
                res.pid             = PID_W'(pick);
                res.resume_pointer  = slot_sp[pick];
            end
            CMD_SPAWN:
            begin
                if (cmd.spawn_level > slot_lvl[me])
                    res.status = 1'b1;
                else
                begin
                    for (n = 1; n < SLOT_COUNT; n++)
                    begin
                        if (!found && slot_st[n] == SLOT_FREE)
                        begin
                            found = 1'b1;
                            pick  = n;
                        end
                    end
                    if (!found)
                        res.status = 1'b1;
                    else
                    begin
                        slot_sp[pick]  = stack_base + WORD_W'(pick * STACK_BYTES)
                                         + WORD_W'(FRAME_OFFSET);
                        slot_lvl[pick] = cmd.spawn_level;
                        slot_par[pick] = PARENT_W'(cmd.spawn_parent);
                        slot_st[pick]  = SLOT_READY;
                        res.pid        = PID_W'(pick);
                    end
                end
            end
            CMD_KILL:
            begin
                victim = cmd.target_pid[PID_W-1:0];
                if (cmd.target_pid == '0 || cmd.target_pid >= SLOT_COUNT)
                    res.status = 1'b1;
                else if (slot_st[victim] == SLOT_FREE)
                    res.status = 1'b1;
                else if (slot_lvl[me] == LVL_USER &&
                         ((victim != me && slot_par[victim] != PARENT_W'(me)) ||
                          slot_lvl[victim] == LVL_SYSTEM))
                    res.status = 1'b1;
                else
                begin
                    adopt_orphans(PARENT_W'(victim), slot_par[victim]);
                    slot_st[victim]  = SLOT_FREE;
                    res.yield_needed = (victim == me);
                end
            end
            default:
            begin
                slot_st[me] = SLOT_ZOMBIE;
                adopt_orphans(PARENT_W'(me), slot_par[me]);
                res.yield_needed = 1'b1;
            end
        endcase
        return res;
    endfunction

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    task automatic report_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: result beat with nothing outstanding, expected none, got %0h",
                         $time, out_data);
                mismatches++;
            end
            else
            begin
                reply_head = replies_due.pop_front();
                report_field("status", reply_head.status, out_data.status);
                report_field("pid", reply_head.pid, out_data.pid);
                report_field("resume_pointer", reply_head.resume_pointer,
                             out_data.resume_pointer);
                report_field("yield_needed", reply_head.yield_needed, out_data.yield_needed);
                replies_checked++;
            end
        end
    end

    task automatic send_command(input rrpt_cmd_code_t code, input logic [WORD_W-1:0] sp,
                                input logic lvl, input logic [2:0] parent,
                                input logic [TARGET_W-1:0] target);
        rrpt_in_t  cmd;
        rrpt_out_t res;
        cmd.command       = code;
        cmd.stack_pointer = sp;
        cmd.spawn_level   = lvl;
        cmd.spawn_parent  = parent;
        cmd.target_pid    = target;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
            @(negedge clk);
        end
        res = run_scheduler_command(cmd);
        replies_due.push_back(res);
        commands_by_code[code]++;
        if (res.status)
            refusals++;
        @(negedge clk);
    endtask

    task automatic finish_phase();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_stack_base(input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        stack_base = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_switch_alone();
        send_command(CMD_SWITCH, 32'h0000_0000, 1'b0, 3'd0, 4'd0);
        send_command(CMD_SWITCH, 32'hFFFF_FFFF, 1'b1, 3'd7, 4'd15);
    endtask

    task automatic test_spawn_fill();
        send_command(CMD_SPAWN, 32'h0, 1'b1, 3'd0, 4'd0);
        send_command(CMD_SPAWN, 32'h0, 1'b0, 3'd7, 4'd0);
        send_command(CMD_SPAWN, 32'h0, 1'b0, 3'd1, 4'd0);
        send_command(CMD_SPAWN, 32'h0, 1'b0, 3'd2, 4'd0);
        send_command(CMD_SPAWN, 32'h0, 1'b0, 3'd2, 4'd0);
        send_command(CMD_SPAWN, 32'h0, 1'b1, 3'd5, 4'd0);
        send_command(CMD_SPAWN, 32'h0, 1'b0, 3'd4, 4'd0);
        send_command(CMD_SPAWN, 32'h0, 1'b0, 3'd3, 4'd0);
    endtask

    task automatic test_kill_rules();
        send_command(CMD_KILL, 32'h0, 1'b0, 3'd0, 4'd0);
        send_command(CMD_KILL, 32'h0, 1'b0, 3'd0, 4'd8);
        send_command(CMD_KILL, 32'h0, 1'b0, 3'd0, 4'd15);
        send_command(CMD_KILL, 32'h0, 1'b0, 3'd0, 4'd6);
        send_command(CMD_KILL, 32'h0, 1'b0, 3'd0, 4'd6);
        send_command(CMD_SWITCH, 32'h1234_5678, 1'b0, 3'd0, 4'd0);
        send_command(CMD_SWITCH, 32'hA5A5_5A5A, 1'b0, 3'd0, 4'd0);
        send_command(CMD_SPAWN, 32'h0, 1'b1, 3'd2, 4'd0);
        send_command(CMD_KILL, 32'h0, 1'b0, 3'd0, 4'd1);
        send_command(CMD_KILL, 32'h0, 1'b0, 3'd0, 4'd3);
        send_command(CMD_KILL, 32'h0, 1'b0, 3'd0, 4'd4);
        send_command(CMD_KILL, 32'h0, 1'b0, 3'd0, 4'd2);
    endtask

    task automatic test_exit_zombie();
        send_command(CMD_SWITCH, 32'h0BAD_F00D, 1'b0, 3'd0, 4'd0);
        send_command(CMD_EXIT, 32'h0, 1'b0, 3'd0, 4'd0);
        send_command(CMD_EXIT, 32'h0, 1'b0, 3'd0, 4'd0);
        send_command(CMD_SWITCH, 32'h7FFF_FFFF, 1'b0, 3'd0, 4'd0);
    endtask

    task automatic test_random_mix(input int count, input int gap_pct, input int hold_pct,
                                   input logic [WORD_W-1:0] base);
        rrpt_cmd_code_t      code;
        logic [TARGET_W-1:0] target;
        int                  pick;
        finish_phase();
        send_gap_pct = gap_pct;
        stall_pct    = hold_pct;
        write_stack_base(base);
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                code = CMD_SWITCH;
            else if (pick < 60)
                code = CMD_SPAWN;
            else if (pick < 88)
                code = CMD_KILL;
            else
                code = CMD_EXIT;
            if ($urandom_range(9) == 0)
                target = TARGET_W'($urandom_range(15));
            else
                target = TARGET_W'($urandom_range(SLOT_COUNT - 1, 1));
            send_command(code, $urandom, 1'($urandom_range(1)), 3'($urandom_range(7)),
                         target);
        end
    endtask

    initial
    begin
        foreach (slot_st[i])
        begin
            slot_st[i]  = SLOT_FREE;
            slot_lvl[i] = LVL_USER;
            slot_par[i] = '0;
            slot_sp[i]  = '0;
        end
        slot_st[0]  = SLOT_RUN;
        slot_lvl[0] = LVL_SYSTEM;
        slot_par[0] = NO_PARENT;
        cur_pid     = '0;
        stack_base  = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_stack_base(32'hFFFF_FFFF);
        test_switch_alone();
        test_spawn_fill();
        test_kill_rules();
        test_exit_zombie();
        test_random_mix(230, 0, 0, 32'h0000_0000);
        test_random_mix(230, 65, 0, $urandom);
        test_random_mix(230, 0, 65, 32'hFFFF_C000);
        test_random_mix(230, 38, 38, 32'h8000_0000);
        finish_phase();

        $display("Covered %0d switch, %0d spawn, %0d kill and %0d exit commands, %0d refused",
                 commands_by_code[CMD_SWITCH], commands_by_code[CMD_SPAWN],
                 commands_by_code[CMD_KILL], commands_by_code[CMD_EXIT], refusals);
        $display("Checked %0d result beats over five stack bases, %0d mismatches",
                 replies_checked, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", replies_due.size());
        $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/rrpt_pkg.sv
rtl/rrpt_ctrl.sv
rtl/rrpt_dp.sv
rtl/round_robin_process_table.sv
tb/sv/tb.sv
